// ===== rtl/i2da_pkg.sv =====
// Shared types, constants and the decimal multiple table for the integer to ASCII converter.
package i2da_pkg;

  localparam int unsigned DecDigits     = 10;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned PosW          = 4;
  localparam int unsigned MagW          = 32;
  localparam int unsigned TabW          = 34;

  localparam logic [5:0] AsciiZero  = 6'd48;
  localparam logic [5:0] AsciiMinus = 6'd45;

  // Multiples k * 10^p for p, k in 0..9; 9 * 10^9 needs 34 bits.
  typedef logic [DecDigits-1:0][DecDigits-1:0][TabW-1:0] dec_tab_t;

  function automatic dec_tab_t dec_build();
    dec_tab_t          tab;
    logic [TabW-1:0]   pw;
    pw = TabW'(1);
    for (int p = 0; p < DecDigits; p++) begin
      for (int k = 0; k < DecDigits; k++) begin
        tab[p][k] = TabW'(k) * pw;
      end
      pw = pw * TabW'(10);
    end
    return tab;
  endfunction

  localparam dec_tab_t DecMult = dec_build();

  // One classified number waiting for conversion.
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
    logic [PosW-1:0] top_pos;
  } item_t;

endpackage

// ===== rtl/i2da_front.sv =====
// Front end: takes input transfers, works out sign, magnitude and digit count.
module i2da_front (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  q_ready_i,
  output logic                  q_valid_o,
  output i2da_pkg::item_t       q_item_o
);
  import i2da_pkg::*;

  logic            neg;
  logic [MagW-1:0] mag;
  logic [PosW-1:0] top_pos;

  always_comb begin
    neg     = !s_axis_tuser && s_axis_tdata[31];
    mag     = neg ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
    top_pos = '0;
    // Count the powers of ten that fit: gives the position of the leading digit.
    for (int p = 1; p < DecDigits; p++) begin
      if ({2'b00, mag} >= DecMult[p][1]) begin
        top_pos = top_pos + 4'd1;
      end
    end
  end

  assign s_axis_tready    = q_ready_i;
  assign q_valid_o        = s_axis_tvalid;
  assign q_item_o.neg     = neg;
  assign q_item_o.mag     = mag;
  assign q_item_o.top_pos = top_pos;

endmodule

// ===== rtl/i2da_queue.sv =====
// Short queue of classified numbers between the front and back ends.
module i2da_queue #(
  parameter int unsigned Depth = i2da_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  i2da_pkg::item_t  push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output i2da_pkg::item_t  pop_item_o
);
  import i2da_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_wr_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q <= PtrW'(Depth - 1))
    else $error("write pointer out of range");

  a_rd_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ptr_q <= PtrW'(Depth - 1))
    else $error("read pointer out of range");
`endif

endmodule

// ===== rtl/i2da_back.sv =====
// Back end: emits any sign and one decimal digit per free cycle, leading first.
module i2da_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  i2da_pkg::item_t  q_item_i,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);
  import i2da_pkg::*;

  logic            busy_q, busy_d;
  logic            sign_q, sign_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            m_valid_q, m_valid_d;
  logic [5:0]      m_char_q, m_char_d;
  logic            m_last_q, m_last_d;

  logic            out_free, step, finish, pop;
  logic [PosW-1:0] digit;
  logic [TabW-1:0] sub;

  assign out_free = !m_valid_q || m_axis_tready;
  assign step     = busy_q && out_free;
  assign finish   = step && !sign_q && (pos_q == '0);
  // Load the next number while idle or on the step that ends the current one.
  assign pop      = q_valid_i && (!busy_q || finish);
  assign q_ready_o = !busy_q || finish;

  always_comb begin
    digit = '0;
    for (int k = 1; k < DecDigits; k++) begin
      if ({2'b00, mag_q} >= DecMult[pos_q][k]) begin
        digit = digit + 4'd1;
      end
    end
    sub = DecMult[pos_q][digit];
  end

  always_comb begin
    busy_d    = busy_q;
    sign_d    = sign_q;
    mag_d     = mag_q;
    pos_d     = pos_q;
    m_valid_d = m_valid_q;
    m_char_d  = m_char_q;
    m_last_d  = m_last_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (step) begin
      m_valid_d = 1'b1;
      if (sign_q) begin
        m_char_d = AsciiMinus;
        m_last_d = 1'b0;
        sign_d   = 1'b0;
      end else begin
        m_char_d = AsciiZero + {2'b00, digit};
        m_last_d = pos_q == '0;
        mag_d    = mag_q - sub[MagW-1:0];
        pos_d    = pos_q - 4'd1;
      end
    end
    if (pop) begin
      busy_d = 1'b1;
      sign_d = q_item_i.neg;
      mag_d  = q_item_i.mag;
      pos_d  = q_item_i.top_pos;
    end else if (finish) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      sign_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      sign_q    <= sign_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    pos_q    <= pos_d;
    m_char_q <= m_char_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_char_q};
  assign m_axis_tlast  = m_last_q;

`ifndef ASSERT_OFF
  a_sign_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sign_q |-> busy_q)
    else $error("sign pending while idle");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q <= 4'd9))
    else $error("digit position out of range");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (m_axis_tvalid && m_axis_tlast))
    else $error("final digit not marked last");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && sign_q) |=> (m_axis_tvalid && !m_axis_tlast && busy_q))
    else $error("sign character ended the number");
`endif

endmodule

// ===== rtl/int_to_decimal_ascii.sv =====
// Path: a number taken while idle is written into the queue, then loaded by the back end, and
// its first character is then registered in the output stage before it can transfer.
// Rate: one character per cycle while the output accepts; a number gives 1 to 11 characters
// (digits + sign), set by the back end, which resolves one decimal digit per step against a
// table of multiples of powers of ten. The queue lets the next number load with no gap.
// Reset: asynchronous, active low; empties the queue, the back end and the output stage.
// Top level of the integer to decimal ASCII converter.
module int_to_decimal_ascii #(
  parameter int unsigned QueueDepth = i2da_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] word
  input  logic        s_axis_tuser,   // [0] op: 0 signed, 1 unsigned
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] char_code, [7:6] zero
  output logic        m_axis_tlast
);
  import i2da_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  i2da_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready_i     (push_ready),
    .q_valid_o     (push_valid),
    .q_item_o      (push_item)
  );

  i2da_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  i2da_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (pop_valid),
    .q_ready_o     (pop_ready),
    .q_item_i      (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
